// ===== hw/rtl/kcl_pkg.sv =====
// Package for the keypad code lock: constants, status and mode codes,
// and the payload and state types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

   localparam int CODE_KEYS = 4;
   localparam int KEY_W = 4;
   localparam int CNT_W = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1;
   localparam int ATTEMPT_W = 4;
   localparam int STATUS_W = 3;
   localparam int ENTERED_W = 2;
   localparam int MODE_W = 2;

   localparam logic [KEY_W-1:0] KEY_CODE_MAX = 4'd11;
   localparam logic [ATTEMPT_W-1:0] ATTEMPT_SAT = 4'd15;
   localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RESET = 4'd3;

   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADMIN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOCKOUT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_TAKEN = 3'd0;
   localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WRONG = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SAVED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ADMIN = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd6;

   typedef logic [CODE_KEYS-1:0][KEY_W-1:0] code_type;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] key_code;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ENTERED_W-1:0] keys_entered;
      logic                 alarm_on;
      logic                 admin_entry;
      logic [ATTEMPT_W-1:0] wrong_count;
   } rsp_type;

   typedef struct packed {
      code_type             stored_code;
      logic [CNT_W-1:0]     key_count;
      logic [ATTEMPT_W-1:0] attempt_count;
      logic                 admin_pending;
      logic [MODE_W-1:0]    lock_mode;
   } lock_state_type;

   function automatic code_type code_reset_value();
      code_type v;
      for (int i = 0; i < CODE_KEYS; i++) begin
         v[i] = KEY_W'(i + 1);
      end
      return v;
   endfunction

   localparam code_type CODE_RESET = code_reset_value();

endpackage

`default_nettype wire

// ===== hw/rtl/kcl_step.sv =====
// Next-state and result logic of the keypad code lock for one event.
// Depends on kcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kcl_step (
   input  var kcl_pkg::lock_state_type       state,
   input  var kcl_pkg::code_type             entry_keys,
   input  var kcl_pkg::req_type              req,
   input  var logic [kcl_pkg::ATTEMPT_W-1:0] max_attempts,
   output kcl_pkg::lock_state_type           state_next,
   output kcl_pkg::code_type                 entry_next,
   output kcl_pkg::rsp_type                  rsp
);

   logic                           key_valid;
   logic                           last_key;
   logic                           match;
   logic [kcl_pkg::ATTEMPT_W-1:0] attempt_inc;
   kcl_pkg::code_type              written;

   always_comb begin
      key_valid = (req.key_code <= kcl_pkg::KEY_CODE_MAX);
      last_key = (state.key_count == kcl_pkg::CNT_W'(kcl_pkg::CODE_KEYS - 1));
      written = entry_keys;
      written[state.key_count] = req.key_code;
      match = (written == state.stored_code);
      attempt_inc = (state.attempt_count < kcl_pkg::ATTEMPT_SAT) ?
                    state.attempt_count + 4'd1 : state.attempt_count;
   end

   always_comb begin
      logic [kcl_pkg::STATUS_W-1:0] status;
      state_next = state;
      entry_next = entry_keys;
      status = kcl_pkg::ST_IGNORED;
      unique case (state.lock_mode)
         kcl_pkg::MODE_LOCKOUT: begin
            if (req.kind) begin
               state_next.attempt_count = '0;
               state_next.lock_mode = kcl_pkg::MODE_NORMAL;
               status = kcl_pkg::ST_CLEARED;
            end
         end
         kcl_pkg::MODE_ADMIN: begin
            if (!req.kind && key_valid) begin
               entry_next = written;
               status = kcl_pkg::ST_TAKEN;
               if (last_key) begin
                  state_next.stored_code = written;
                  state_next.key_count = '0;
                  state_next.admin_pending = 1'b0;
                  state_next.attempt_count = '0;
                  state_next.lock_mode = kcl_pkg::MODE_NORMAL;
                  status = kcl_pkg::ST_SAVED;
               end else begin
                  state_next.key_count = state.key_count + kcl_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
            state_next.lock_mode = kcl_pkg::MODE_NORMAL;
            if (req.kind) begin
               state_next.admin_pending = 1'b1;
               status = kcl_pkg::ST_ADMIN;
            end else if (key_valid) begin
               entry_next = written;
               status = kcl_pkg::ST_TAKEN;
               if (last_key) begin
                  state_next.key_count = '0;
                  if (match) begin
                     state_next.attempt_count = '0;
                     status = kcl_pkg::ST_GRANTED;
                     if (state.admin_pending) begin
                        state_next.lock_mode = kcl_pkg::MODE_ADMIN;
                     end
                  end else begin
                     state_next.attempt_count = attempt_inc;
                     status = kcl_pkg::ST_WRONG;
                     if (attempt_inc >= max_attempts) begin
                        if (state.admin_pending) begin
                           state_next.admin_pending = 1'b0;
                           state_next.attempt_count = '0;
                        end else begin
                           state_next.lock_mode = kcl_pkg::MODE_LOCKOUT;
                        end
                     end else if (state.admin_pending) begin
                        state_next.lock_mode = kcl_pkg::MODE_ADMIN;
                     end
                  end
               end else begin
                  state_next.key_count = state.key_count + kcl_pkg::CNT_W'(1);
               end
            end
         end
      endcase
      rsp.status = status;
      rsp.keys_entered = kcl_pkg::ENTERED_W'(state_next.key_count);
      rsp.alarm_on = (state_next.lock_mode == kcl_pkg::MODE_LOCKOUT);
      rsp.admin_entry = (state_next.lock_mode == kcl_pkg::MODE_ADMIN);
      rsp.wrong_count = state_next.attempt_count;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/keypad_code_lock_top.sv =====
// Keypad code lock top level: input register, lock state, result register.
// A request passes through the input register and then the result register
// before its response is valid.
// Throughput is one transfer per cycle unless rsp_ready stalls the result
// register, set by the single update step between the input and result registers.
// Synchronous active-high reset restores code 1234, clears the counts and
// sets max_attempts to 3; the entry key store holds no reset value.
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_lock_top (
   input  var logic                              clock,
   input  var logic                              reset,
   input  var logic                              req_valid,
   output logic                                  req_ready,
   input  var kcl_pkg::req_type                  req_data,
   output logic                                  rsp_valid,
   input  var logic                              rsp_ready,
   output kcl_pkg::rsp_type                      rsp_data,
   input  var logic                              csr_wr_en,
   input  var logic [kcl_pkg::ATTEMPT_W-1:0]     csr_wr_data
);

   kcl_pkg::req_type               req_ff;
   logic                           req_valid_ff;
   logic                           req_valid_in;
   kcl_pkg::rsp_type               rsp_ff;
   kcl_pkg::rsp_type               rsp_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   kcl_pkg::lock_state_type        state_ff;
   kcl_pkg::lock_state_type        state_in;
   kcl_pkg::code_type              entry_keys_ff;
   kcl_pkg::code_type              entry_keys_in;
   logic [kcl_pkg::ATTEMPT_W-1:0] max_attempts_ff;
   logic                           advance;
   logic                           req_take;

   assign advance = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take = req_valid && req_ready;

   kcl_step u_step (
      .state        (state_ff),
      .entry_keys   (entry_keys_ff),
      .req          (req_ff),
      .max_attempts (max_attempts_ff),
      .state_next   (state_in),
      .entry_next   (entry_keys_in),
      .rsp          (rsp_in)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (advance) begin
         req_valid_in = 1'b0;
      end
      if (req_take) begin
         req_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_attempts_ff <= kcl_pkg::MAX_ATTEMPTS_RESET;
         state_ff.stored_code <= kcl_pkg::CODE_RESET;
         state_ff.key_count <= '0;
         state_ff.attempt_count <= '0;
         state_ff.admin_pending <= 1'b0;
         state_ff.lock_mode <= kcl_pkg::MODE_NORMAL;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_attempts_ff <= csr_wr_data;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
         entry_keys_ff <= entry_keys_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // A lockout always starts and stays with an empty entry and no pending admin press.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.lock_mode == kcl_pkg::MODE_LOCKOUT |->
         state_ff.key_count == '0 && !state_ff.admin_pending)
      else $error("lockout with partial entry or pending admin press");

   // A held request must not be dropped while the result register is full.
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_ff))
      else $error("buffered request lost while stalled");

   // The alarm and admin entry are never reported together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.alarm_on && rsp_ff.admin_entry))
      else $error("alarm and admin entry both set");

   // A granted entry leaves the wrong-entry count cleared.
   assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.status == kcl_pkg::ST_GRANTED |=>
         state_ff.attempt_count == '0)
      else $error("attempt count not cleared after grant");

endmodule

`default_nettype wire
